[rtl/sdc_pkg.sv]
package sdc_pkg;

	typedef enum logic [1:0] {
		K_START = 2'd0,
		K_RX    = 2'd1,
		K_TICK  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_READY,
		PH_STUFF,
		PH_R1,
		PH_POST
	} phase_t;

	typedef enum logic [1:0] {
		REG_READY_TO = 2'd0,
		REG_RESP_TO  = 2'd1,
		REG_MAX_ATT  = 2'd2
	} reg_idx_t;

	localparam logic       OK_SEND    = 1'b0;
	localparam logic       OK_DONE    = 1'b1;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ERR     = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic [7:0] POLL_BYTE  = 8'hFF;
	localparam logic [7:0] STOP_HEAD  = 8'h4C;
	localparam logic [1:0] START_BITS = 2'b01;
	localparam int         R1_BUSY    = 7;
	localparam int         R1_CRC_ERR = 3;
	localparam logic [6:0] CRC7_TAPS  = 7'h09;
	localparam int         CRC_BITS   = 40;
	localparam int         FRAME_BYTES = 6;

	localparam logic [15:0] READY_TO_RST = 16'd300;
	localparam logic [15:0] RESP_TO_RST  = 16'd50;
	localparam logic [3:0]  MAX_ATT_RST  = 4'd3;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  command_index;
		logic [31:0] argument;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] ready_timeout_ticks;
		logic [15:0] response_timeout_ticks;
		logic [3:0]  max_attempts;
	} cfg_t;

	// one result, or a burst: six frame bytes then a poll byte
	typedef struct packed {
		logic        valid;
		logic        burst;
		logic        out_kind;
		logic [7:0]  tx_byte;
		logic        expects_reply;
		logic [1:0]  status;
		logic [7:0]  r1_byte;
		logic [47:0] frame;
	} res_t;

	function automatic logic [6:0] crc7_step(input logic [6:0] c);
		crc7_step = {c[5:0], 1'b0} ^ (c[6] ? CRC7_TAPS : 7'h00);
	endfunction

	// CRC contribution of a single set bit at position pos (LSB = fed last)
	function automatic logic [6:0] crc7_col(input int pos);
		logic [6:0] c;
		c = CRC7_TAPS;
		for (int k = 0; k < CRC_BITS - 1; k++) begin
			if (k < pos)
				c = crc7_step(c);
		end
		return c;
	endfunction

	function automatic logic [6:0] crc7(input logic [CRC_BITS-1:0] d);
		logic [6:0] c;
		c = 7'h00;
		for (int i = 0; i < CRC_BITS; i++) begin
			if (d[i])
				c = c ^ crc7_col(i);
		end
		return c;
	endfunction

endpackage

[rtl/sdc_ctrl.sv]
module sdc_ctrl
	import sdc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_s1,
	input  item_t item_s1,
	input  cfg_t  cfg,
	input  logic  free,
	output logic  fire,
	output logic  load,
	output res_t  res
);

	phase_t      phase_q, phase_d;
	logic [47:0] frame_q, frame_d;
	logic [3:0]  att_q, att_d;
	logic [15:0] el_q, el_d;
	logic [7:0]  r1_q, r1_d;

	logic [47:0] new_frame;
	logic        new_stop, frame_stop, rx_ff, ready_ok, resp_ok, att_over;
	logic [3:0]  att_n;
	logic [39:0] body;

	assign body       = {START_BITS, item_s1.command_index, item_s1.argument};
	assign new_frame  = {body, crc7(body), 1'b1};
	assign new_stop   = new_frame[47:40] == STOP_HEAD;
	assign frame_stop = frame_q[47:40] == STOP_HEAD;
	assign rx_ff      = item_s1.rx_byte == POLL_BYTE;
	assign ready_ok   = el_q < cfg.ready_timeout_ticks;
	assign resp_ok    = el_q < cfg.response_timeout_ticks;
	assign att_n      = att_q + 4'd1;
	assign att_over   = (att_n >= cfg.max_attempts) || (att_n == 4'd0);

	assign fire = valid_s1 && (!res.valid || free);
	assign load = fire && res.valid;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (item_s1.kind)
			K_START: begin
				if (phase_q == PH_IDLE)
					phase_d = new_stop ? PH_STUFF : PH_READY;
			end
			K_RX: begin
				case (phase_q)
					PH_READY: begin
						if (rx_ff)
							phase_d = frame_stop ? PH_STUFF : PH_R1;
						else if (!ready_ok)
							phase_d = PH_IDLE;
					end
					PH_STUFF: phase_d = PH_R1;
					PH_R1: begin
						if (item_s1.rx_byte[R1_BUSY])
							phase_d = resp_ok ? PH_R1 : PH_IDLE;
						else if (item_s1.rx_byte[R1_CRC_ERR])
							phase_d = att_over ? PH_IDLE : (frame_stop ? PH_STUFF : PH_READY);
						else
							phase_d = frame_stop ? PH_POST : PH_IDLE;
					end
					PH_POST: begin
						if (rx_ff || !ready_ok)
							phase_d = PH_IDLE;
					end
					default: phase_d = phase_q;
				endcase
			end
			default: phase_d = phase_q;
		endcase
	end

	// results and data updates
	always_comb begin
		res     = '0;
		frame_d = frame_q;
		att_d   = att_q;
		el_d    = el_q;
		r1_d    = r1_q;
		case (item_s1.kind)
			K_START: begin
				if (phase_q == PH_IDLE) begin
					frame_d   = new_frame;
					att_d     = 4'd0;
					res.valid = 1'b1;
					if (new_stop) begin
						res.burst = 1'b1;
						res.frame = new_frame;
					end else begin
						res.tx_byte       = POLL_BYTE;
						res.expects_reply = 1'b1;
						el_d              = 16'd0;
					end
				end
			end
			K_TICK: begin
				if (phase_q != PH_IDLE && el_q != 16'hFFFF)
					el_d = el_q + 16'd1;
			end
			K_RX: begin
				case (phase_q)
					PH_READY: begin
						res.valid = 1'b1;
						if (rx_ff) begin
							res.burst = 1'b1;
							res.frame = frame_q;
							if (!frame_stop)
								el_d = 16'd0;
						end else if (ready_ok) begin
							res.tx_byte       = POLL_BYTE;
							res.expects_reply = 1'b1;
							el_d              = 16'd0;
						end else begin
							res.out_kind = OK_DONE;
							res.status   = ST_TIMEOUT;
							res.r1_byte  = r1_q;
						end
					end
					PH_STUFF: begin
						res.valid         = 1'b1;
						res.tx_byte       = POLL_BYTE;
						res.expects_reply = 1'b1;
						el_d              = 16'd0;
					end
					PH_R1: begin
						res.valid = 1'b1;
						r1_d      = item_s1.rx_byte;
						if (item_s1.rx_byte[R1_BUSY]) begin
							if (resp_ok) begin
								res.tx_byte       = POLL_BYTE;
								res.expects_reply = 1'b1;
								el_d              = 16'd0;
							end else begin
								res.out_kind = OK_DONE;
								res.status   = ST_TIMEOUT;
								res.r1_byte  = item_s1.rx_byte;
							end
						end else if (item_s1.rx_byte[R1_CRC_ERR]) begin
							att_d = att_n;
							if (att_over) begin
								res.out_kind = OK_DONE;
								res.status   = ST_ERR;
								res.r1_byte  = item_s1.rx_byte;
							end else if (frame_stop) begin
								res.burst = 1'b1;
								res.frame = frame_q;
							end else begin
								res.tx_byte       = POLL_BYTE;
								res.expects_reply = 1'b1;
								el_d              = 16'd0;
							end
						end else if (frame_stop) begin
							res.tx_byte       = POLL_BYTE;
							res.expects_reply = 1'b1;
							el_d              = 16'd0;
						end else begin
							res.out_kind = OK_DONE;
							res.status   = ST_OK;
							res.r1_byte  = item_s1.rx_byte;
						end
					end
					PH_POST: begin
						res.valid = 1'b1;
						if (rx_ff) begin
							res.out_kind = OK_DONE;
							res.status   = ST_OK;
							res.r1_byte  = r1_q;
						end else if (ready_ok) begin
							res.tx_byte       = POLL_BYTE;
							res.expects_reply = 1'b1;
							el_d              = 16'd0;
						end else begin
							res.out_kind = OK_DONE;
							res.status   = ST_ERR;
							res.r1_byte  = r1_q;
						end
					end
					default: res.valid = 1'b0;
				endcase
			end
			default: res.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			frame_q <= '0;
			att_q   <= '0;
			el_q    <= '0;
			r1_q    <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			frame_q <= frame_d;
			att_q   <= att_d;
			el_q    <= el_d;
			r1_q    <= r1_d;
		end
	end

endmodule

[rtl/sdc_tx_seq.sv]
module sdc_tx_seq
	import sdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // tx_byte, expects_reply, status, r1, zero pad
	output logic [0:0]  m_tuser,  // out_kind
	output logic        m_tlast
);

	logic        valid_q;
	logic [2:0]  rem_q;
	logic [39:0] shift_q;
	logic        kind_q, exp_q, last_q;
	logic [7:0]  tx_q, r1_q;
	logic [1:0]  st_q;
	logic        xfer;

	assign xfer     = valid_q && m_tready;
	assign free     = !valid_q || (m_tready && rem_q == 3'd0);
	assign m_tvalid = valid_q;
	assign m_tdata  = {5'b0, r1_q, st_q, exp_q, tx_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			rem_q   <= res.burst ? 3'(FRAME_BYTES) : 3'd0;
		end else if (xfer) begin
			if (rem_q == 3'd0)
				valid_q <= 1'b0;
			else
				rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= res.out_kind;
			st_q    <= res.status;
			r1_q    <= res.r1_byte;
			shift_q <= res.frame[39:0];
			if (res.burst) begin
				tx_q   <= res.frame[47:40];
				exp_q  <= 1'b0;
				last_q <= 1'b0;
			end else begin
				tx_q   <= res.tx_byte;
				exp_q  <= res.expects_reply;
				last_q <= 1'b1;
			end
		end else if (xfer && rem_q != 3'd0) begin
			if (rem_q == 3'd1) begin
				// closing poll after the frame
				tx_q   <= POLL_BYTE;
				exp_q  <= 1'b1;
				last_q <= 1'b1;
			end else begin
				tx_q    <= shift_q[39:32];
				shift_q <= {shift_q[31:0], 8'h00};
			end
		end
	end

endmodule

[rtl/sd_spi_command_engine.sv]
// Host-side SD card SPI command engine. Input transfers carry a kind in s_tuser
// (start, received byte, millisecond tick); results ask for a byte exchange or
// report completion with status and the R1 byte. An input item is held in the
// input register and processed there combinationally; a new item can be taken
// every cycle while the held item does not wait. An item that sends a command
// frame (a CMD12 start or CMD12 retry, or the card answering ready before any
// other command) yields seven results (six frame bytes and a poll), any other
// item at most one. The output sequencer sends one result per cycle while
// m_tready is high, so an item that yields results is held in the input register
// until the previous item's last result is being transferred; items without
// results (ticks, ignored items) never wait. The user must write configuration
// via cfg_we/cfg_index/cfg_data while the engine is idle (not enforced).
module sd_spi_command_engine
	import sdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // command_index, argument, rx_byte, zero pad
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // tx_byte, expects_reply, status, r1, zero pad
	output logic [0:0]  m_tuser,   // out_kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic  valid_s1;
	item_t item_s1;
	cfg_t  cfg_q;
	logic  fire, load, free;
	res_t  res;

	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind          <= kind_t'(s_tuser);
			item_s1.command_index <= s_tdata[5:0];
			item_s1.argument      <= s_tdata[37:6];
			item_s1.rx_byte       <= s_tdata[45:38];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_timeout_ticks    <= READY_TO_RST;
			cfg_q.response_timeout_ticks <= RESP_TO_RST;
			cfg_q.max_attempts           <= MAX_ATT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_READY_TO: cfg_q.ready_timeout_ticks    <= cfg_data;
				REG_RESP_TO:  cfg_q.response_timeout_ticks <= cfg_data;
				REG_MAX_ATT:  cfg_q.max_attempts           <= cfg_data[3:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	sdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.cfg      (cfg_q),
		.free     (free),
		.fire     (fire),
		.load     (load),
		.res      (res)
	);

	sdc_tx_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[rtl/sdc_checker.sv]
module sdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	// completion always closes the run and sends nothing
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[8:0] == 9'd0
			&& m_tdata[10:9] != 2'd3)
		else $error("bad completion result");

	// send results carry no status
	a_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[18:9] == 10'd0)
		else $error("send result with status");

	// a run that ends in a send ends in a poll
	a_poll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser[0] |-> m_tdata[8] && m_tdata[7:0] == 8'hFF)
		else $error("run ends without poll");

endmodule

bind sd_spi_command_engine sdc_checker u_chk (.*);
